@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master controller.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BufDepth = 32;
  localparam int unsigned BufAw    = $clog2(BufDepth);
  localparam int unsigned CntW     = $clog2(BufDepth + 2);

  // operation codes
  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpOpen  = 3'd1;
  localparam logic [2:0] OpQueue = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;
  localparam logic [2:0] OpPop   = 3'd5;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StAddrNack = 2'd1;
  localparam logic [1:0] StDataNack = 2'd2;

  // config register indexes
  localparam logic CfgHalfPeriod = 1'b0;
  localparam logic CfgStretch    = 1'b1;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] target_address;
    logic [7:0] data_byte;
    logic [7:0] read_quantity;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic       scl_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [5:0] received_count;
    logic [7:0] read_data;
    logic       accepted;
    logic [5:0] rx_available;
  } out_item_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [19:0] stretch_timeout;
  } cfg_t;

endpackage

@@ rtl/i2cm_seq.sv @@
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer, byte queues and command decode; one tick per step.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cm_pkg::in_item_t  item_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  output i2cm_pkg::out_item_t res_o
);
  import i2cm_pkg::*;

  localparam logic [3:0] SIdle = 4'd0,  SStA = 4'd1,  SStB = 4'd2,  SStC = 4'd3;
  localparam logic [3:0] SStD  = 4'd4,  SWbD = 4'd5,  SWbH = 4'd6,  SWbL = 4'd7;
  localparam logic [3:0] SRbD  = 4'd8,  SRbH = 4'd9,  SRbS = 4'd10, SRbL = 4'd11;
  localparam logic [3:0] SSpA  = 4'd12, SSpB = 4'd13, SSpC = 4'd14;

  logic [3:0]      state_q, state_d;
  logic [15:0]     phase_q, phase_d;
  logic [19:0]     stretch_q, stretch_d;
  logic [3:0]      bit_q, bit_d;
  logic [CntW-1:0] byte_q, byte_d;
  logic [7:0]      shift_q, shift_d;
  logic [6:0]      addr_q, addr_d;
  logic            wopen_q, wopen_d;
  logic [CntW-1:0] txlen_q, txlen_d;
  logic [CntW-1:0] rxlen_q, rxlen_d;
  logic [CntW-1:0] rxidx_q, rxidx_d;
  logic [CntW-1:0] reqcnt_q, reqcnt_d;
  logic            isrd_q, isrd_d;
  logic            drive_q, drive_d;
  logic [1:0]      status_q, status_d;
  logic [CntW-1:0] lastrx_q, lastrx_d;

  logic [7:0] tx_mem [BufDepth];
  logic [7:0] rx_mem [BufDepth];

  logic            tx_we, rx_we;
  logic [BufAw-1:0] tx_waddr, rx_waddr;
  logic [7:0]      tx_wdata, rx_wdata;

  logic [16:0]     hp, phase_inc;
  logic            waits, done, acc, txm;
  logic [7:0]      rdata;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] qty_cl;
  logic            go;

  always_comb begin
    state_d = state_q; phase_d = phase_q; stretch_d = stretch_q; bit_d = bit_q;
    byte_d = byte_q; shift_d = shift_q; addr_d = addr_q; wopen_d = wopen_q;
    txlen_d = txlen_q; rxlen_d = rxlen_q; rxidx_d = rxidx_q; reqcnt_d = reqcnt_q;
    isrd_d = isrd_q; drive_d = drive_q; status_d = status_q; lastrx_d = lastrx_q;
    tx_we = 1'b0; tx_waddr = txlen_q[BufAw-1:0]; tx_wdata = item_i.data_byte;
    rx_we = 1'b0; rx_waddr = rxlen_q[BufAw-1:0]; rx_wdata = shift_q;
    done = 1'b0; acc = 1'b0; rdata = 8'd0; go = 1'b0; idx = '0; txm = 1'b0;
    hp = (cfg_i.half_period == 16'd0) ? 17'd1 : {1'b0, cfg_i.half_period};
    phase_inc = {1'b0, phase_q} + 17'd1;
    waits = (state_q == SStB) || (state_q == SWbH) || (state_q == SRbH) ||
            (state_q == SSpB);
    qty_cl = (item_i.read_quantity > 8'(BufDepth)) ? CntW'(BufDepth)
                                                   : CntW'(item_i.read_quantity);

    if (state_q != SIdle) begin
      if (waits && phase_q == 16'd0 && !item_i.scl_in &&
          stretch_q < cfg_i.stretch_timeout) begin
        stretch_d = stretch_q + 20'd1;
      end else if (phase_inc < hp) begin
        phase_d = phase_inc[15:0];
      end else begin
        phase_d = 16'd0; stretch_d = 20'd0;
        txm = (byte_q == '0) || !isrd_q;
        unique case (state_q)
          SStA: state_d = SStB;
          SStB: state_d = SStC;
          SStC: state_d = SStD;
          SStD: begin
            bit_d = 4'd0; drive_d = shift_q[7]; state_d = SWbD;
          end
          SWbD: state_d = SWbH;
          SWbH: state_d = SWbL;
          SWbL: begin
            if (txm) begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d = bit_q + 4'd1;
              if (bit_d < 4'd8) begin
                drive_d = shift_d[7]; state_d = SWbD;
              end else state_d = SRbD;
            end else begin
              byte_d = byte_q + CntW'(1); go = 1'b1;
            end
          end
          SRbD: state_d = SRbH;
          SRbH: state_d = SRbS;
          SRbS: begin
            shift_d = {shift_q[6:0], item_i.sda_in}; state_d = SRbL;
          end
          SRbL: begin
            if (txm) begin
              if (shift_q[0]) begin
                status_d = (byte_q == '0) ? StAddrNack : StDataNack;
                state_d = SSpA;
              end else begin
                if (isrd_q && byte_q == '0) begin
                  rxlen_d = '0; rxidx_d = '0;
                end
                byte_d = byte_q + CntW'(1); go = 1'b1;
              end
            end else begin
              bit_d = bit_q + 4'd1;
              if (bit_d < 4'd8) state_d = SRbD;
              else begin
                if (rxlen_q < CntW'(BufDepth)) rx_we = 1'b1;
                rxlen_d = rxlen_q + CntW'(1);
                drive_d = (byte_q == reqcnt_q);
                state_d = SWbD;
              end
            end
          end
          SSpA: state_d = SSpB;
          SSpB: state_d = SSpC;
          default: begin
            state_d = SIdle; done = 1'b1;
            if (isrd_q) begin
              lastrx_d = (status_q == StOk) ? rxlen_q : '0;
              if (status_q == StOk) rxidx_d = '0;
            end else if (status_q == StOk) begin
              txlen_d = '0; wopen_d = 1'b0;
            end
          end
        endcase
        // move on to the next byte or to STOP
        if (go) begin
          idx = byte_d - CntW'(1);
          bit_d = 4'd0;
          if (isrd_q) begin
            if (idx < reqcnt_q) begin
              shift_d = 8'd0; state_d = SRbD;
            end else state_d = SSpA;
          end else if (idx < txlen_q && idx < CntW'(BufDepth)) begin
            shift_d = tx_mem[idx[BufAw-1:0]]; drive_d = shift_d[7]; state_d = SWbD;
          end else state_d = SSpA;
        end
      end
    end else begin
      case (item_i.operation)
        OpOpen: begin
          addr_d = item_i.target_address; txlen_d = '0; wopen_d = 1'b1; acc = 1'b1;
        end
        OpQueue: begin
          if (wopen_q && txlen_q < CntW'(BufDepth)) begin
            tx_we = 1'b1; txlen_d = txlen_q + CntW'(1); acc = 1'b1;
          end
        end
        OpWrite: begin
          if (wopen_q) begin
            isrd_d = 1'b0; shift_d = {addr_q, 1'b0}; byte_d = '0; bit_d = 4'd0;
            status_d = StOk; state_d = SStA; phase_d = 16'd0; stretch_d = 20'd0;
            acc = 1'b1;
          end
        end
        OpRead: begin
          reqcnt_d = qty_cl;
          isrd_d = 1'b1; shift_d = {item_i.target_address, 1'b1}; byte_d = '0;
          bit_d = 4'd0; status_d = StOk; state_d = SStA; phase_d = 16'd0;
          stretch_d = 20'd0; acc = 1'b1;
        end
        OpPop: begin
          if (rxidx_q < rxlen_q && rxidx_q < CntW'(BufDepth)) begin
            rdata = rx_mem[rxidx_q[BufAw-1:0]]; rxidx_d = rxidx_q + CntW'(1);
            acc = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (state_d == SWbD || state_d == SWbH || state_d == SWbL) begin
      res_o.sda_pull_low = !drive_d;
    end else begin
      res_o.sda_pull_low = (state_d == SStC) || (state_d == SStD) ||
                           (state_d == SSpA) || (state_d == SSpB);
    end
    res_o.scl_pull_low = (state_d == SStD) || (state_d == SWbD) || (state_d == SWbL) ||
                         (state_d == SRbD) || (state_d == SRbL) || (state_d == SSpA);
    res_o.busy_res       = (state_d != SIdle);
    res_o.done_res       = done;
    res_o.status         = status_d;
    res_o.received_count = 6'(lastrx_d);
    res_o.read_data      = rdata;
    res_o.accepted       = acc;
    res_o.rx_available   = (rxlen_d >= rxidx_d) ? 6'(rxlen_d - rxidx_d) : 6'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; phase_q <= '0; stretch_q <= '0; bit_q <= '0; byte_q <= '0;
      shift_q <= '0; addr_q <= '0; wopen_q <= 1'b0; txlen_q <= '0; rxlen_q <= '0;
      rxidx_q <= '0; reqcnt_q <= '0; isrd_q <= 1'b0; drive_q <= 1'b0;
      status_q <= StOk; lastrx_q <= '0;
    end else if (step_i) begin
      state_q <= state_d; phase_q <= phase_d; stretch_q <= stretch_d; bit_q <= bit_d;
      byte_q <= byte_d; shift_q <= shift_d; addr_q <= addr_d; wopen_q <= wopen_d;
      txlen_q <= txlen_d; rxlen_q <= rxlen_d; rxidx_q <= rxidx_d; reqcnt_q <= reqcnt_d;
      isrd_q <= isrd_d; drive_q <= drive_d; status_q <= status_d; lastrx_q <= lastrx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && tx_we) tx_mem[tx_waddr] <= tx_wdata;
    if (step_i && rx_we) rx_mem[rx_waddr] <= rx_wdata;
  end

endmodule

@@ rtl/i2c_master_controller_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_controller_core
// Open-drain I2C master, 7-bit addressing, one input beat per bus tick.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_item_t
//   out     | output    | out_valid/out_ready | out_item_t
//   cfg     | input     | cfg_valid/cfg_ready | index, 20-bit data
//
// One beat per cycle while in_ready is high: each input beat is processed in
// the cycle it is taken and its result lands in the output register, which
// also holds it under stall. in_ready drops only while a result waits and
// out_ready is low. Reset clears the sequencer, counters and queue lengths;
// config returns to 500 / 100000. Config writes are taken every cycle.
module i2c_master_controller_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [19:0]         cfg_data_i
);
  import i2cm_pkg::*;

  cfg_t      cfg_q;
  out_item_t res, res_q;
  logic      out_valid_q, step;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period     <= 16'd500;
      cfg_q.stretch_timeout <= 20'd100000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHalfPeriod: cfg_q.half_period     <= cfg_data_i[15:0];
        CfgStretch:    cfg_q.stretch_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res && !res_q.accepted)
    else $error("done pulse while busy or with a command");
  a_rx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.rx_available <= 6'(BufDepth))
    else $error("receive count beyond buffer depth");
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.read_data != 8'd0 |-> res_q.accepted)
    else $error("read data without accepted pop");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("result lost under stall");

endmodule
